// ----- src/oaht_pkg.sv -----
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants for the open-addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

  // Slot count; a power of two, the probe start is the low key bits.
  localparam int TABLE_SLOTS = 256;
  localparam int IDX_W       = $clog2(TABLE_SLOTS);

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 64;
  localparam int LIMIT_W = 8;
  localparam int USED_W  = 9;

  // 0.75 of the slot count
  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = LIMIT_W'((TABLE_SLOTS * 3) / 4);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_state_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_VALUE,
    S_RESULT
  } eng_state_t;

  typedef struct packed {
    slot_state_t      state;
    logic [KEY_W-1:0] key;
  } meta_t;

  typedef struct packed {
    logic               flag;
    logic [VALUE_W-1:0] value_out;
    logic               status;
  } rsp_t;

  typedef struct packed {
    logic               meta_we;
    logic [IDX_W-1:0]   meta_waddr;
    meta_t              meta_wdata;
    logic [IDX_W-1:0]   meta_raddr;
    logic               val_we;
    logic [IDX_W-1:0]   val_waddr;
    logic [VALUE_W-1:0] val_wdata;
    logic [IDX_W-1:0]   val_raddr;
  } mem_req_t;

endpackage

// ----- src/oaht_ifs.sv -----
// ----------------------------------------------------------------------------
// oaht_req_if / oaht_rsp_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface oaht_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] key_hash;
  logic [63:0] value_in;

  modport source(output valid, output command, output key_hash, output value_in,
                 input ready);
  modport sink(input valid, input command, input key_hash, input value_in,
               output ready);
endinterface

interface oaht_rsp_if;
  logic        valid;
  logic        ready;
  logic        flag;
  logic [63:0] value_out;
  logic        status;

  modport source(output valid, output flag, output value_out, output status,
                 input ready);
  modport sink(input valid, input flag, input value_out, input status,
               output ready);
endinterface

// ----- src/oaht_ram.sv -----
// ----------------------------------------------------------------------------
// oaht_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/oaht_engine.sv -----
// ----------------------------------------------------------------------------
// oaht_engine
// Probe sequencer: clears the slot states, walks the probe chain one slot
// per cycle, and issues the read-modify-write of the slot memories.
// ----------------------------------------------------------------------------
module oaht_engine
  import oaht_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [LIMIT_W-1:0] load_limit,
  oaht_req_if.sink           req,
  input  logic               out_free,
  output logic               res_valid,
  output rsp_t               res,
  output mem_req_t           mem,
  input  meta_t              meta_rdata,
  input  logic [VALUE_W-1:0] val_rdata
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

  eng_state_t         st, st_next;
  cmd_t               cmd, cmd_next;
  logic [KEY_W-1:0]   key, key_next;
  logic [VALUE_W-1:0] val, val_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [IDX_W-1:0]   cnt, cnt_next;
  logic               tomb_seen, tomb_seen_next;
  logic [IDX_W-1:0]   tomb_idx, tomb_idx_next;
  logic [USED_W-1:0]  used_count, used_count_next;
  rsp_t               res_next;

  logic               is_empty, is_hit, is_tomb, is_last;
  logic               free_ok, free_empty, full;
  logic [IDX_W-1:0]   free_idx;

  assign is_empty = meta_rdata.state == SLOT_EMPTY;
  assign is_tomb  = meta_rdata.state == SLOT_TOMB;
  assign is_hit   = meta_rdata.state == SLOT_USED && meta_rdata.key == key;
  assign is_last  = cnt == LAST_IDX;

  // first tombstone wins, else the empty slot that ended the walk
  always_comb begin
    free_ok    = tomb_seen || is_tomb || is_empty;
    free_empty = !tomb_seen && !is_tomb && is_empty;
    free_idx   = tomb_seen ? tomb_idx : idx;
    full       = !free_ok || (free_empty && used_count >= USED_W'(load_limit));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_CLEAR;
      idx        <= '0;
      used_count <= '0;
    end else begin
      st         <= st_next;
      idx        <= idx_next;
      used_count <= used_count_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd       <= cmd_next;
    key       <= key_next;
    val       <= val_next;
    cnt       <= cnt_next;
    tomb_seen <= tomb_seen_next;
    tomb_idx  <= tomb_idx_next;
    res       <= res_next;
  end

  always_comb begin
    st_next         = st;
    cmd_next        = cmd;
    key_next        = key;
    val_next        = val;
    idx_next        = idx;
    cnt_next        = cnt;
    tomb_seen_next  = tomb_seen;
    tomb_idx_next   = tomb_idx;
    used_count_next = used_count;
    res_next        = res;
    res_valid       = 1'b0;
    req.ready       = 1'b0;
    mem             = '0;
    mem.meta_raddr  = idx + 1'b1;
    mem.val_raddr   = idx;

    case (st)
      S_CLEAR: begin
        mem.meta_we    = 1'b1;
        mem.meta_waddr = idx;
        mem.meta_wdata = '{state: SLOT_EMPTY, key: '0};
        idx_next       = idx + 1'b1;
        if (idx == LAST_IDX) begin
          st_next = S_IDLE;
        end
      end

      S_IDLE: begin
        req.ready      = 1'b1;
        mem.meta_raddr = req.key_hash[IDX_W-1:0];
        if (req.valid) begin
          cmd_next       = cmd_t'(req.command);
          key_next       = req.key_hash;
          val_next       = req.value_in;
          idx_next       = req.key_hash[IDX_W-1:0];
          cnt_next       = '0;
          tomb_seen_next = 1'b0;
          res_next       = '0;
          if (req.command inside {CMD_INSERT, CMD_LOOKUP, CMD_REMOVE}) begin
            st_next = S_PROBE;
          end else begin
            st_next = S_RESULT;
          end
        end
      end

      S_PROBE: begin
        if (is_hit) begin
          st_next = S_RESULT;
          case (cmd)
            CMD_INSERT: begin
              mem.val_we    = 1'b1;
              mem.val_waddr = idx;
              mem.val_wdata = val;
            end
            CMD_LOOKUP: begin
              st_next = S_VALUE;
            end
            CMD_REMOVE: begin
              mem.meta_we    = 1'b1;
              mem.meta_waddr = idx;
              mem.meta_wdata = '{state: SLOT_TOMB, key: key};
              res_next.flag  = 1'b1;
            end
            default: begin
            end
          endcase
        end else if (is_empty || is_last) begin
          st_next = S_RESULT;
          if (cmd == CMD_INSERT) begin
            if (full) begin
              res_next.status = 1'b1;
            end else begin
              mem.meta_we    = 1'b1;
              mem.meta_waddr = free_idx;
              mem.meta_wdata = '{state: SLOT_USED, key: key};
              mem.val_we     = 1'b1;
              mem.val_waddr  = free_idx;
              mem.val_wdata  = val;
              res_next.flag  = 1'b1;
              if (free_empty) begin
                used_count_next = used_count + 1'b1;
              end
            end
          end
        end else begin
          if (is_tomb && !tomb_seen) begin
            tomb_seen_next = 1'b1;
            tomb_idx_next  = idx;
          end
          idx_next = idx + 1'b1;
          cnt_next = cnt + 1'b1;
        end
      end

      S_VALUE: begin
        res_next = '{flag: 1'b1, value_out: val_rdata, status: 1'b0};
        st_next  = S_RESULT;
      end

      S_RESULT: begin
        res_valid = 1'b1;
        if (out_free) begin
          st_next = S_IDLE;
        end
      end

      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_used_step: assert property (@(posedge clk) disable iff (rst)
    used_count == $past(used_count) || used_count == $past(used_count) + 1'b1)
    else $error("used count moved by more than one");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> st == S_PROBE || st == S_RESULT)
    else $error("accepted beat did not start a probe");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_free |=> res_valid && $stable(res))
    else $error("pending result changed while stalled");

  a_probe_walk: assert property (@(posedge clk) disable iff (rst)
    st == S_PROBE && $past(st) == S_PROBE |-> idx == $past(idx) + 1'b1)
    else $error("probe skipped a slot");
`endif

endmodule

// ----- src/open_address_hash_table.sv -----
// ----------------------------------------------------------------------------
// open_address_hash_table
// Open-addressing hash table, linear probing with tombstones.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot-state memory, all TABLE_SLOTS (256)
// slots, with req.ready low; configuration writes are taken during the sweep.
// Commands are handled one at a time. The probe walk reads one slot of the
// key/state memory per cycle, from the start slot until a hit, an empty slot
// or the last of TABLE_SLOTS slots; a lookup that hits then reads the value
// memory. A command with the unused code skips the probe. A finished result
// sits in the output register, so the next command is taken while it waits.
// ----------------------------------------------------------------------------
module open_address_hash_table
  import oaht_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  oaht_req_if.sink           req,
  oaht_rsp_if.source         rsp,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  logic [LIMIT_W-1:0]      load_limit;
  logic                    out_free;
  logic                    res_valid;
  rsp_t                    res;
  mem_req_t                mem;
  logic [$bits(meta_t)-1:0] meta_raw;
  logic [VALUE_W-1:0]      val_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_limit <= LOAD_LIMIT_RESET;
    end else if (cfg_we) begin
      load_limit <= cfg_wdata;
    end
  end

  oaht_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .load_limit (load_limit),
    .req        (req),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res),
    .mem        (mem),
    .meta_rdata (meta_t'(meta_raw)),
    .val_rdata  (val_rdata)
  );

  oaht_ram #(
    .WIDTH ($bits(meta_t)),
    .DEPTH (TABLE_SLOTS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (mem.meta_we),
    .waddr (mem.meta_waddr),
    .wdata (mem.meta_wdata),
    .raddr (mem.meta_raddr),
    .rdata (meta_raw)
  );

  oaht_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_SLOTS)
  ) u_value_ram (
    .clk   (clk),
    .we    (mem.val_we),
    .waddr (mem.val_waddr),
    .wdata (mem.val_wdata),
    .raddr (mem.val_raddr),
    .rdata (val_rdata)
  );

  assign out_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_valid && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      rsp.flag      <= res.flag;
      rsp.value_out <= res.value_out;
      rsp.status    <= res.status;
    end
  end

endmodule

// ----- tb/oaht_table_mirror.sv -----
// ----------------------------------------------------------------------------
// oaht_table_mirror
// Watches the command, result and load-limit ports of the hash table, keeps
// a shadow copy of the slot array, and checks each result beat in order
// against the result that the shadow table gives for the command.
// ----------------------------------------------------------------------------
module oaht_table_mirror
  import oaht_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  oaht_req_if                req,
  oaht_rsp_if                rsp,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  output int                 fail_count,
  output int                 pending
);

  slot_state_t        slot_st  [TABLE_SLOTS];
  logic [KEY_W-1:0]   slot_key [TABLE_SLOTS];
  logic [VALUE_W-1:0] slot_val [TABLE_SLOTS];
  logic [USED_W-1:0]  used_cnt;
  logic [LIMIT_W-1:0] limit;
  rsp_t               due_results[$];

  task automatic mirror_command(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                                input logic [VALUE_W-1:0] val, output rsp_t res);
    int idx;
    int n;
    int hit;
    int tomb;
    int free_at;
    bit free_empty;
    res = '0;
    hit = -1;
    tomb = -1;
    free_at = -1;
    free_empty = 1'b0;
    idx = int'(key % TABLE_SLOTS);
    for (n = 0; n < TABLE_SLOTS && hit < 0 && free_at < 0; n++) begin
      case (slot_st[idx])
        SLOT_EMPTY: begin
          if (tomb >= 0) begin
            free_at = tomb;
          end else begin
            free_at = idx;
            free_empty = 1'b1;
          end
        end
        SLOT_USED: begin
          if (slot_key[idx] == key) hit = idx;
        end
        default: begin
          if (tomb < 0) tomb = idx;
        end
      endcase
      idx = (idx + 1) % TABLE_SLOTS;
    end
    if (hit < 0 && free_at < 0) free_at = tomb;

    case (cmd)
      CMD_INSERT: begin
        if (hit >= 0) begin
          slot_val[hit] = val;
        end else if (free_at < 0 || (free_empty && used_cnt >= limit)) begin
          res.status = 1'b1;
        end else begin
          if (free_empty) used_cnt = used_cnt + 1'b1;
          slot_st[free_at]  = SLOT_USED;
          slot_key[free_at] = key;
          slot_val[free_at] = val;
          res.flag = 1'b1;
        end
      end
      CMD_LOOKUP: begin
        if (hit >= 0) begin
          res.flag = 1'b1;
          res.value_out = slot_val[hit];
        end
      end
      CMD_REMOVE: begin
        if (hit >= 0) begin
          slot_st[hit] = SLOT_TOMB;
          res.flag = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (rst) begin
      foreach (slot_st[i]) slot_st[i] = SLOT_EMPTY;
      used_cnt = '0;
      limit = LOAD_LIMIT_RESET;
      due_results.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.flag = rsp.flag;
        got.value_out = rsp.value_out;
        got.status = rsp.status;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result beat: flag %0b value_out %h status %0b",
                   $time, got.flag, got.value_out, got.status);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (got.flag !== want.flag) begin
            $display("%0t: flag expected %0b got %0b", $time, want.flag, got.flag);
            fail_count++;
          end
          if (got.value_out !== want.value_out) begin
            $display("%0t: value_out expected %h got %h", $time, want.value_out,
                     got.value_out);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0b got %0b", $time, want.status, got.status);
            fail_count++;
          end
        end
      end
      if (cfg_we) limit = cfg_wdata;
      if (req.valid && req.ready) begin
        mirror_command(req.command, req.key_hash, req.value_in, want);
        due_results.push_back(want);
      end
      pending <= due_results.size();
    end
  end

endmodule

// ----- tb/open_address_hash_table_test.sv -----
// ----------------------------------------------------------------------------
// open_address_hash_table_test
// Drives directed and random insert, lookup and remove traffic with clustered
// keys through several load limits, with random stalls on both channels, and
// reports the verdict from the mirror's failure count.
// ----------------------------------------------------------------------------
module open_address_hash_table_test;
  import oaht_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RSP_HOLD_CYCLES = 400;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;
  int                 fail_count;
  int                 pending;
  bit                 steady;
  bit                 rsp_hold;
  logic [KEY_W-1:0]   known_keys[$];

  oaht_req_if req_if();
  oaht_rsp_if rsp_if();

  open_address_hash_table dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  oaht_table_mirror mirror (
    .clk        (clk),
    .rst        (rst),
    .req        (req_if),
    .rsp        (rsp_if),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("open_address_hash_table regression: fail");
    $finish;
  end

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_hold) begin
        rsp_if.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
      end else begin
        rsp_if.ready <= steady || ($urandom_range(99) >= 7);
      end
    end
  end

  task automatic send_cmd(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                          input logic [VALUE_W-1:0] val);
    int gap;
    if (!steady && $urandom_range(99) < 7) begin
      gap = $urandom_range(1, 6);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.command  <= cmd;
    req_if.key_hash <= key;
    req_if.value_in <= val;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic drain;
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] lim);
    cfg_we    <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_traffic(input int count, input int insert_pct, input bit wide);
    int pick;
    logic [1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [7:0] lo;
    logic [VALUE_W-1:0] val;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 3) cmd = CMD_UNUSED;
      else if (pick < 3 + insert_pct) cmd = CMD_INSERT;
      else if (pick < 3 + insert_pct + (97 - insert_pct) * 2 / 3) cmd = CMD_LOOKUP;
      else cmd = CMD_REMOVE;
      if (known_keys.size() > 0 && $urandom_range(99) < 55) begin
        key = known_keys[$urandom_range(known_keys.size() - 1)];
      end else begin
        if (wide) lo = 8'($urandom);
        else if ($urandom_range(1)) lo = 8'($urandom_range(0, 23));
        else lo = 8'($urandom_range(244, 267));
        if ($urandom_range(99) < 8) key = $urandom;
        else key = {20'd0, 4'($urandom_range(15)), lo};
        if (cmd == CMD_INSERT) begin
          known_keys.push_back(key);
          if (known_keys.size() > 64) void'(known_keys.pop_front());
        end
      end
      val = {$urandom, $urandom};
      send_cmd(cmd, key, val);
      if ($urandom_range(99) == 0) drain();
    end
  endtask

  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    req_if.valid    <= 1'b0;
    req_if.command  <= CMD_INSERT;
    req_if.key_hash <= '0;
    req_if.value_in <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(CMD_LOOKUP, 32'h0000_0000, 64'h0);
    send_cmd(CMD_INSERT, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 64'h0);
    send_cmd(CMD_LOOKUP, 32'h0000_0000, 64'h0);
    send_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(CMD_INSERT, 32'h0000_0000, 64'hAAAA_AAAA_AAAA_AAAA);
    send_cmd(CMD_LOOKUP, 32'h0000_0000, 64'h0);
    send_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 64'h0);
    send_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 64'h0);
    send_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 64'h0);
    send_cmd(CMD_INSERT, 32'h0000_0100, 64'h5555_5555_5555_5555);
    send_cmd(CMD_INSERT, 32'h0000_01FF, 64'h0123_4567_89AB_CDEF);
    send_cmd(CMD_INSERT, 32'h0000_02FF, 64'hFEDC_BA98_7654_3210);
    send_cmd(CMD_LOOKUP, 32'h0000_02FF, 64'h0);
    send_cmd(CMD_REMOVE, 32'h0000_0100, 64'h0);
    send_cmd(CMD_INSERT, 32'h0000_0300, 64'h8000_0000_0000_0001);
    send_cmd(CMD_LOOKUP, 32'h0000_0300, 64'h0);
    drain();

    write_limit(8'd1);
    send_cmd(CMD_INSERT, 32'h0000_0005, 64'h1);
    send_cmd(CMD_REMOVE, 32'h0000_02FF, 64'h0);
    send_cmd(CMD_INSERT, 32'h0000_0402, 64'h2);
    send_cmd(CMD_LOOKUP, 32'h0000_0402, 64'h0);
    drain();

    write_limit(8'd0);
    send_cmd(CMD_INSERT, 32'h0000_0007, 64'h3);
    send_cmd(CMD_LOOKUP, 32'h0000_0005, 64'h0);
    drain();

    write_limit(8'd64);
    run_traffic(150, 45, 1'b0);
    rsp_hold <= 1'b1;
    run_traffic(30, 45, 1'b0);
    run_traffic(120, 45, 1'b0);
    drain();

    write_limit(8'd255);
    run_traffic(350, 70, 1'b1);
    drain();

    write_limit(8'd128);
    steady <= 1'b1;
    run_traffic(100, 40, 1'b0);
    steady <= 1'b0;
    run_traffic(100, 40, 1'b0);
    drain();

    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("open_address_hash_table regression: pass");
    end else begin
      $display("open_address_hash_table regression: fail");
    end
    $finish;
  end

endmodule
